>>> hw/rtl/adsr_pkg.sv
// adsr_pkg: shared widths and configuration register indexes for the adsr envelope block
// no dependencies

package adsr_pkg;

    localparam int TICK_W    = 64;
    localparam int LVL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = LVL_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_NOTE_START    = 3'd0;
    localparam t_cfg_idx CFG_ATTACK_LEN    = 3'd1;
    localparam t_cfg_idx CFG_DECAY_LEN     = 3'd2;
    localparam t_cfg_idx CFG_SUSTAIN_LEVEL = 3'd3;
    localparam t_cfg_idx CFG_HOLD_LEN      = 3'd4;
    localparam t_cfg_idx CFG_RELEASE_LEN   = 3'd5;
    localparam t_cfg_idx CFG_PEAK_LEVEL    = 3'd6;

endpackage

>>> hw/rtl/adsr_cfg.sv
// adsr_cfg: configuration registers plus registered sustain level and zone end sums
// depends on adsr_pkg

module adsr_cfg
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_idx            i_cfg_index,
    input  logic [TICK_W-1:0]   i_cfg_data,
    output logic [TICK_W-1:0]   o_note_start,
    output logic [LEN_BITS-1:0] o_attack_len,
    output logic [LEN_BITS-1:0] o_decay_len,
    output logic [LEN_BITS-1:0] o_hold_len,
    output logic [LEN_BITS-1:0] o_release_len,
    output logic [LVL_W-1:0]    o_peak_level,
    output logic [LVL_W-1:0]    o_sus_level,
    output logic [LEN_BITS:0]   o_ad_sum,
    output logic [LEN_BITS:0]   o_hr_sum
);

    logic [TICK_W-1:0]   r_note_start;
    logic [LEN_BITS-1:0] r_attack_len;
    logic [LEN_BITS-1:0] r_decay_len;
    logic [LVL_W-1:0]    r_sustain_level;
    logic [LEN_BITS-1:0] r_hold_len;
    logic [LEN_BITS-1:0] r_release_len;
    logic [LVL_W-1:0]    r_peak_level;
    logic [LVL_W-1:0]    r_sus_level;
    logic [LEN_BITS:0]   r_ad_sum;
    logic [LEN_BITS:0]   r_hr_sum;
    logic [2*LVL_W-1:0]  n_sus_prod;

    assign o_cfg_ready = 1'b1;
    assign n_sus_prod  = r_peak_level * r_sustain_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_start    <= '0;
            r_attack_len    <= '0;
            r_decay_len     <= '0;
            r_sustain_level <= '0;
            r_hold_len      <= '0;
            r_release_len   <= '0;
            r_peak_level    <= '0;
            r_sus_level     <= '0;
            r_ad_sum        <= '0;
            r_hr_sum        <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NOTE_START:    r_note_start    <= i_cfg_data;
                    CFG_ATTACK_LEN:    r_attack_len    <= i_cfg_data[LEN_BITS-1:0];
                    CFG_DECAY_LEN:     r_decay_len     <= i_cfg_data[LEN_BITS-1:0];
                    CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_data[LVL_W-1:0];
                    CFG_HOLD_LEN:      r_hold_len      <= i_cfg_data[LEN_BITS-1:0];
                    CFG_RELEASE_LEN:   r_release_len   <= i_cfg_data[LEN_BITS-1:0];
                    CFG_PEAK_LEVEL:    r_peak_level    <= i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
            r_sus_level <= n_sus_prod[2*LVL_W-1:LVL_W];
            r_ad_sum    <= {1'b0, r_attack_len} + {1'b0, r_decay_len};
            r_hr_sum    <= {1'b0, r_hold_len} + {1'b0, r_release_len};
        end
    end

    assign o_note_start  = r_note_start;
    assign o_attack_len  = r_attack_len;
    assign o_decay_len   = r_decay_len;
    assign o_hold_len    = r_hold_len;
    assign o_release_len = r_release_len;
    assign o_peak_level  = r_peak_level;
    assign o_sus_level   = r_sus_level;
    assign o_ad_sum      = r_ad_sum;
    assign o_hr_sum      = r_hr_sum;

endmodule

>>> hw/rtl/adsr_front.sv
// adsr_front: four pipeline stages from query time to ramp numerator and length
// depends on adsr_pkg; configuration values come from adsr_cfg

module adsr_front
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    output logic                       o_rdy,
    input  logic [TICK_W-1:0]          i_now_tick,
    input  logic [TICK_W-1:0]          i_note_start,
    input  logic [LEN_BITS-1:0]        i_attack_len,
    input  logic [LEN_BITS-1:0]        i_decay_len,
    input  logic [LEN_BITS-1:0]        i_hold_len,
    input  logic [LEN_BITS-1:0]        i_release_len,
    input  logic [LVL_W-1:0]           i_peak_level,
    input  logic [LVL_W-1:0]           i_sus_level,
    input  logic [LEN_BITS:0]          i_ad_sum,
    input  logic [LEN_BITS:0]          i_hr_sum,
    output logic                       o_vld,
    input  logic                       i_rdy,
    output logic [LEN_BITS+LVL_W-1:0]  o_num,
    output logic [LEN_BITS-1:0]        o_den,
    output logic                       o_act
);

    localparam int NW = LEN_BITS + LVL_W;

    typedef enum logic [2:0] {
        ZN_OFF,
        ZN_ATK,
        ZN_DEC,
        ZN_SUS,
        ZN_REL
    } t_zone;

    // stage a: offset from note start
    logic              r_a_vld;
    logic [TICK_W-1:0] r_a_e;
    logic              r_a_ge;
    // stage b: zone and ramp offsets
    logic                r_b_vld;
    t_zone               r_b_zone;
    logic [LEN_BITS-1:0] r_b_x;
    logic [LEN_BITS-1:0] r_b_y;
    logic                r_b_act;
    // stage c: products
    logic                r_c_vld;
    t_zone               r_c_zone;
    logic [NW-1:0]       r_c_p1;
    logic [NW-1:0]       r_c_p2;
    logic [LEN_BITS-1:0] r_c_den;
    logic                r_c_act;
    // stage d: numerator
    logic                r_d_vld;
    logic [NW-1:0]       r_d_num;
    logic [LEN_BITS-1:0] r_d_den;
    logic                r_d_act;

    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d = !r_d_vld || i_rdy;
    assign rdy_c = !r_c_vld || rdy_d;
    assign rdy_b = !r_b_vld || rdy_c;
    assign rdy_a = !r_a_vld || rdy_b;
    assign o_rdy = rdy_a;

    // stage b logic
    logic                e_hi_zero, e_hi1_zero;
    logic [LEN_BITS-1:0] e_lo;
    logic [LEN_BITS:0]   e_lo1;
    logic                lt_atk, lt_ad, lt_hold, lt_hr;
    logic [LEN_BITS:0]   d_dec, y_dec, y_rel;
    t_zone               n_b_zone;
    logic [LEN_BITS-1:0] n_b_x, n_b_y;
    logic                n_b_act;

    assign e_hi_zero  = (r_a_e[TICK_W-1:LEN_BITS] == '0);
    assign e_hi1_zero = (r_a_e[TICK_W-1:LEN_BITS+1] == '0);
    assign e_lo       = r_a_e[LEN_BITS-1:0];
    assign e_lo1      = r_a_e[LEN_BITS:0];
    assign lt_atk     = e_hi_zero && (e_lo < i_attack_len);
    assign lt_hold    = e_hi_zero && (e_lo < i_hold_len);
    assign lt_ad      = e_hi1_zero && (e_lo1 < i_ad_sum);
    assign lt_hr      = e_hi1_zero && (e_lo1 < i_hr_sum);
    assign d_dec      = e_lo1 - {1'b0, i_attack_len};
    assign y_dec      = i_ad_sum - e_lo1;
    assign y_rel      = i_hr_sum - e_lo1;
    assign n_b_act    = r_a_ge && lt_hr;

    always_comb begin
        n_b_zone = ZN_OFF;
        n_b_x    = '0;
        n_b_y    = '0;
        priority if (!n_b_act) begin
            n_b_zone = ZN_OFF;
        end else if (lt_atk) begin
            n_b_zone = ZN_ATK;
            n_b_x    = e_lo;
        end else if (lt_ad) begin
            n_b_zone = ZN_DEC;
            n_b_x    = d_dec[LEN_BITS-1:0];
            n_b_y    = y_dec[LEN_BITS-1:0];
        end else if (lt_hold) begin
            n_b_zone = ZN_SUS;
        end else begin
            n_b_zone = ZN_REL;
            n_b_x    = y_rel[LEN_BITS-1:0];
        end
    end

    // stage c logic
    logic [LVL_W-1:0]    c_a1;
    logic [LEN_BITS-1:0] n_c_den;
    logic [NW-1:0]       n_c_p1, n_c_p2;

    always_comb begin
        c_a1    = i_sus_level;
        n_c_den = LEN_BITS'(1);
        unique case (r_b_zone)
            ZN_ATK: begin
                c_a1    = i_peak_level;
                n_c_den = i_attack_len;
            end
            ZN_DEC: n_c_den = i_decay_len;
            ZN_REL: n_c_den = i_release_len;
            ZN_OFF, ZN_SUS: n_c_den = LEN_BITS'(1);
            default: n_c_den = LEN_BITS'(1);
        endcase
    end

    assign n_c_p1 = {{LEN_BITS{1'b0}}, c_a1} * {{LVL_W{1'b0}}, r_b_x};
    assign n_c_p2 = {{LEN_BITS{1'b0}}, i_peak_level} * {{LVL_W{1'b0}}, r_b_y};

    // stage d logic
    logic [NW-1:0] n_d_num;

    assign n_d_num = (r_c_zone == ZN_SUS) ? {{LEN_BITS{1'b0}}, i_sus_level}
                                          : (r_c_p1 + r_c_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_vld;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_vld) begin
            r_a_e  <= i_now_tick - i_note_start;
            r_a_ge <= (i_now_tick >= i_note_start);
        end
        if (rdy_b && r_a_vld) begin
            r_b_zone <= n_b_zone;
            r_b_x    <= n_b_x;
            r_b_y    <= n_b_y;
            r_b_act  <= n_b_act;
        end
        if (rdy_c && r_b_vld) begin
            r_c_zone <= r_b_zone;
            r_c_p1   <= n_c_p1;
            r_c_p2   <= n_c_p2;
            r_c_den  <= n_c_den;
            r_c_act  <= r_b_act;
        end
        if (rdy_d && r_c_vld) begin
            r_d_num <= n_d_num;
            r_d_den <= r_c_den;
            r_d_act <= r_c_act;
        end
    end

    assign o_vld = r_d_vld;
    assign o_num = r_d_num;
    assign o_den = r_d_den;
    assign o_act = r_d_act;

endmodule

>>> hw/rtl/adsr_div_step.sv
// adsr_div_step: one registered restoring-division step, one quotient bit per stage
// depends on adsr_pkg

module adsr_div_step
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  logic [LEN_BITS-1:0] i_rem,
    input  logic [LVL_W-1:0]    i_low,
    input  logic [LEN_BITS-1:0] i_den,
    input  logic                i_act,
    output logic                o_vld,
    input  logic                i_rdy,
    output logic [LEN_BITS-1:0] o_rem,
    output logic [LVL_W-1:0]    o_low,
    output logic [LEN_BITS-1:0] o_den,
    output logic                o_act
);

    logic                r_vld;
    logic [LEN_BITS-1:0] r_rem;
    logic [LVL_W-1:0]    r_low;
    logic [LEN_BITS-1:0] r_den;
    logic                r_act;

    logic [LEN_BITS:0]   rem_part;
    logic [LEN_BITS:0]   rem_diff;
    logic                q_bit;
    logic                rdy_up;

    assign rdy_up   = !r_vld || i_rdy;
    assign o_rdy    = rdy_up;
    assign rem_part = {i_rem, i_low[LVL_W-1]};
    assign rem_diff = rem_part - {1'b0, i_den};
    assign q_bit    = (rem_part >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy_up) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_up && i_vld) begin
            r_rem <= q_bit ? rem_diff[LEN_BITS-1:0] : rem_part[LEN_BITS-1:0];
            r_low <= {i_low[LVL_W-2:0], q_bit};
            r_den <= i_den;
            r_act <= i_act;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_den = r_den;
    assign o_act = r_act;

endmodule

>>> hw/rtl/adsr_envelope_value_top.sv
// adsr_envelope_value_top: ADSR envelope level as a function of query time
// depends on adsr_pkg, adsr_cfg, adsr_front, adsr_div_step
//
// One time query is taken per clock while the output is not stalled, and one
// level comes back per query, in order. Four front stages (offset from note start,
// zone decode, ramp products, numerator sum) feed sixteen divider stages, each of
// which does one LEN_BITS+1 bit compare and subtract to produce one quotient bit.
// Every stage holds its own valid bit, so a stalled output only backs up the
// stages behind it while empty stages keep accepting. Configuration writes are
// always taken and must be made while no query is in flight.

module adsr_envelope_value_top
    import adsr_pkg::*;
#(
    parameter int LEN_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_idx          i_cfg_index,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [TICK_W-1:0] i_now_tick,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [LVL_W-1:0]  o_level,
    output logic              o_is_active
);

    localparam int NW = LEN_BITS + LVL_W;

    logic [TICK_W-1:0]   w_note_start;
    logic [LEN_BITS-1:0] w_attack_len;
    logic [LEN_BITS-1:0] w_decay_len;
    logic [LEN_BITS-1:0] w_hold_len;
    logic [LEN_BITS-1:0] w_release_len;
    logic [LVL_W-1:0]    w_peak_level;
    logic [LVL_W-1:0]    w_sus_level;
    logic [LEN_BITS:0]   w_ad_sum;
    logic [LEN_BITS:0]   w_hr_sum;

    logic [NW-1:0]       w_num;

    logic                w_vld [0:DIV_STEPS];
    logic                w_rdy [0:DIV_STEPS];
    logic [LEN_BITS-1:0] w_rem [0:DIV_STEPS];
    logic [LVL_W-1:0]    w_low [0:DIV_STEPS];
    logic [LEN_BITS-1:0] w_den [0:DIV_STEPS];
    logic                w_act [0:DIV_STEPS];

    adsr_cfg #(
        .LEN_BITS (LEN_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_note_start  (w_note_start),
        .o_attack_len  (w_attack_len),
        .o_decay_len   (w_decay_len),
        .o_hold_len    (w_hold_len),
        .o_release_len (w_release_len),
        .o_peak_level  (w_peak_level),
        .o_sus_level   (w_sus_level),
        .o_ad_sum      (w_ad_sum),
        .o_hr_sum      (w_hr_sum)
    );

    adsr_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (i_in_valid),
        .o_rdy         (o_in_ready),
        .i_now_tick    (i_now_tick),
        .i_note_start  (w_note_start),
        .i_attack_len  (w_attack_len),
        .i_decay_len   (w_decay_len),
        .i_hold_len    (w_hold_len),
        .i_release_len (w_release_len),
        .i_peak_level  (w_peak_level),
        .i_sus_level   (w_sus_level),
        .i_ad_sum      (w_ad_sum),
        .i_hr_sum      (w_hr_sum),
        .o_vld         (w_vld[0]),
        .i_rdy         (w_rdy[0]),
        .o_num         (w_num),
        .o_den         (w_den[0]),
        .o_act         (w_act[0])
    );

    // numerator high part is always below the length, so it seeds the remainder
    assign w_rem[0] = w_num[NW-1:LVL_W];
    assign w_low[0] = w_num[LVL_W-1:0];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        adsr_div_step #(
            .LEN_BITS (LEN_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k]),
            .o_rdy   (w_rdy[k]),
            .i_rem   (w_rem[k]),
            .i_low   (w_low[k]),
            .i_den   (w_den[k]),
            .i_act   (w_act[k]),
            .o_vld   (w_vld[k+1]),
            .i_rdy   (w_rdy[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_low   (w_low[k+1]),
            .o_den   (w_den[k+1]),
            .o_act   (w_act[k+1])
        );
    end

    assign w_rdy[DIV_STEPS] = i_out_ready;
    assign o_out_valid      = w_vld[DIV_STEPS];
    assign o_level          = w_low[DIV_STEPS];
    assign o_is_active      = w_act[DIV_STEPS];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: random and directed level queries against the adsr envelope block
// depends on adsr_pkg and adsr_envelope_value_top; a scoreboard class predicts each level

import adsr_pkg::*;

typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             active;
} t_envelope_point;

class envelope_scoreboard #(int LEN_BITS = 32);
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] attack_len;
    logic [TICK_W-1:0] decay_len;
    logic [TICK_W-1:0] sustain_level;
    logic [TICK_W-1:0] hold_len;
    logic [TICK_W-1:0] release_len;
    logic [TICK_W-1:0] peak_level;
    t_envelope_point   expected_q[$];
    logic [TICK_W-1:0] tick_q[$];
    int                mismatches;

    function new();
        start_tick    = '0;
        attack_len    = '0;
        decay_len     = '0;
        sustain_level = '0;
        hold_len      = '0;
        release_len   = '0;
        peak_level    = '0;
        mismatches    = 0;
    endfunction

    function void set_register(t_cfg_idx idx, logic [TICK_W-1:0] data);
        logic [TICK_W-1:0] len_mask;
        len_mask = (64'd1 << LEN_BITS) - 64'd1;
        case (idx)
            CFG_NOTE_START:    start_tick    = data;
            CFG_ATTACK_LEN:    attack_len    = data & len_mask;
            CFG_DECAY_LEN:     decay_len     = data & len_mask;
            CFG_SUSTAIN_LEVEL: sustain_level = data & 64'hFFFF;
            CFG_HOLD_LEN:      hold_len      = data & len_mask;
            CFG_RELEASE_LEN:   release_len   = data & len_mask;
            CFG_PEAK_LEVEL:    peak_level    = data & 64'hFFFF;
            default: ;
        endcase
    endfunction

    // lengths are at most 32 bits and levels 16, so 64-bit sums and products never wrap
    function t_envelope_point point_at(logic [TICK_W-1:0] tick);
        t_envelope_point   pt;
        logic [TICK_W-1:0] e;
        logic [TICK_W-1:0] off;
        logic [TICK_W-1:0] sus;
        logic [TICK_W-1:0] lvl;
        pt  = '0;
        lvl = '0;
        if (tick >= start_tick) begin
            e = tick - start_tick;
            if (e < hold_len + release_len) begin
                pt.active = 1'b1;
                sus = (peak_level * sustain_level) >> 16;
                if (e < attack_len) begin
                    lvl = (peak_level * e) / attack_len;
                end else if (e < attack_len + decay_len) begin
                    off = e - attack_len;
                    lvl = (sus * off + peak_level * (decay_len - off)) / decay_len;
                end else if (e < hold_len) begin
                    lvl = sus;
                end else begin
                    off = e - hold_len;
                    lvl = (sus * (release_len - off)) / release_len;
                end
            end
        end
        pt.level = lvl[LVL_W-1:0];
        return pt;
    endfunction

    function void note_query(logic [TICK_W-1:0] tick);
        expected_q.push_back(point_at(tick));
        tick_q.push_back(tick);
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", what);
    endfunction

    function void check_result(logic [LVL_W-1:0] level, logic active);
        t_envelope_point   want;
        logic [TICK_W-1:0] tick;
        if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result level %h active %b", level, active));
            return;
        end
        want = expected_q.pop_front();
        tick = tick_q.pop_front();
        if (level !== want.level || active !== want.active)
            flag($sformatf("tick %h: expected level %h active %b, got level %h active %b",
                           tick, want.level, want.active, level, active));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;

    localparam int LEN_BITS    = 32;
    localparam int CYCLE_LIMIT = 300000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index;
    logic [TICK_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [TICK_W-1:0] i_now_tick;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [LVL_W-1:0]  o_level;
    logic              o_is_active;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;

    envelope_scoreboard #(LEN_BITS) sb;

    adsr_envelope_value_top #(
        .LEN_BITS(LEN_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_now_tick (i_now_tick),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_level    (o_level),
        .o_is_active(o_is_active)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_query(i_now_tick);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_level, o_is_active);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_query(logic [TICK_W-1:0] tick);
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk);
        i_in_valid = 1'b1;
        i_now_tick = tick;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [TICK_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // junk in the upper bits checks that each register keeps only its width
    task automatic program_envelope(logic [63:0] start, logic [31:0] att, logic [31:0] dec,
                                    logic [15:0] sus, logic [31:0] hold, logic [31:0] rel,
                                    logic [15:0] peak);
        write_reg(CFG_NOTE_START, start);
        write_reg(CFG_ATTACK_LEN, {$urandom, att});
        write_reg(CFG_DECAY_LEN, {$urandom, dec});
        write_reg(CFG_SUSTAIN_LEVEL, {$urandom, 16'($urandom_range(65535)), sus});
        write_reg(CFG_HOLD_LEN, {$urandom, hold});
        write_reg(CFG_RELEASE_LEN, {$urandom, rel});
        write_reg(CFG_PEAK_LEVEL, {$urandom, 16'($urandom_range(65535)), peak});
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] short_len(int top);
        return ($urandom_range(4) == 0) ? 32'd0 : 32'($urandom_range(top, 1));
    endfunction

    // aim about half of the ticks at or near zone boundaries, with the rest uniform or fully random
    function automatic logic [TICK_W-1:0] pick_tick();
        logic [TICK_W-1:0] mark;
        logic [TICK_W-1:0] span;
        span = sb.hold_len + sb.release_len;
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return sb.start_tick - $urandom_range(64, 1);
            2, 3, 4, 5: begin
                case ($urandom_range(4))
                    0: mark = '0;
                    1: mark = sb.attack_len;
                    2: mark = sb.attack_len + sb.decay_len;
                    3: mark = sb.hold_len;
                    default: mark = span;
                endcase
                return sb.start_tick + mark + $urandom_range(6) - 64'd3;
            end
            9: return sb.start_tick + {31'd0, 1'($urandom_range(1)), $urandom};
            default: return sb.start_tick + ({$urandom, $urandom} % (span + 64'd8));
        endcase
    endfunction

    initial begin
        logic [TICK_W-1:0] ticks_a [11];
        logic [TICK_W-1:0] ticks_b [6];
        logic [TICK_W-1:0] ticks_c [4];

        ticks_a     = '{999, 1000, 1005, 1010, 1020, 1030, 1049, 1050, 1065, 1079, 1080};
        ticks_b     = '{0, 19, 39, 40, 49, 50};
        ticks_c     = '{4, 5, 14, 15};
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_NOTE_START;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_now_tick  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers at reset: nothing is ever active
        send_query('0);
        send_query('1);
        drain();

        // every zone in order
        program_envelope(64'd1000, 32'd10, 32'd20, 16'h8000, 32'd50, 32'd30, 16'hFFFF);
        foreach (ticks_a[k])
            send_query(ticks_a[k]);
        drain();

        // no attack, decay running past the hold point
        program_envelope(64'd0, 32'd0, 32'd40, 16'hFFFF, 32'd20, 32'd30, 16'h1234);
        foreach (ticks_b[k])
            send_query(ticks_b[k]);
        drain();

        // hold ends inside attack, no decay and no release
        program_envelope(64'd5, 32'd30, 32'd0, 16'h0000, 32'd10, 32'd0, 16'hFFFF);
        foreach (ticks_c[k])
            send_query(ticks_c[k]);

        for (int p = 0; p < 10; p++) begin
            drain();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            if (p == 0)
                program_envelope(64'hFFFF_FFFF_0000_0000 + $urandom_range(255),
                                 '1, '1, 16'hFFFF, '1, '1, 16'hFFFF);
            else if (p == 1)
                program_envelope('1, short_len(40), short_len(40), 16'($urandom),
                                 short_len(120), short_len(60), 16'($urandom));
            else if ($urandom_range(3) == 0)
                program_envelope({$urandom, $urandom}, $urandom, $urandom, 16'($urandom),
                                 $urandom, $urandom, 16'($urandom));
            else
                program_envelope({$urandom, $urandom}, short_len(40), short_len(40),
                                 16'($urandom), short_len(120), short_len(60),
                                 16'($urandom));
            for (int k = 0; k < 85; k++) begin
                if (k == 42)
                    drain();
                send_query(pick_tick());
            end
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_cfg.sv
hw/rtl/adsr_front.sv
hw/rtl/adsr_div_step.sv
hw/rtl/adsr_envelope_value_top.sv
tb/testbench.sv
